// ----- rtl/core/tse_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tse_pkg;

    localparam int TRIG_FRAC    = 30;
    localparam int MID_FRAC     = 26;
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_W     = 34;
    localparam int TRIG_W       = 32;
    localparam int OUT_W        = 24;
    localparam int NUM_KINDS    = 7;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = CORDIC_W'(652032874);

    localparam logic [15:0] MAJOR_RESET = 16'd6144;
    localparam logic [15:0] MINOR_RESET = 16'd2048;

    localparam logic REG_MAJOR = 1'b0;
    localparam logic REG_MINOR = 1'b1;

    typedef enum logic [2:0] {
        KIND_POS    = 3'd0,
        KIND_DU     = 3'd1,
        KIND_DV     = 3'd2,
        KIND_NORMAL = 3'd3,
        KIND_DUU    = 3'd4,
        KIND_DUV    = 3'd5,
        KIND_DVV    = 3'd6
    } vector_kind_t;

    typedef struct packed {
        logic [15:0] u_angle;
        logic [15:0] v_angle;
        logic        batch_end_in;
    } in_item_t;

    typedef struct packed {
        logic [2:0]               vector_kind;
        logic signed [OUT_W-1:0]  comp_x;
        logic signed [OUT_W-1:0]  comp_y;
        logic signed [OUT_W-1:0]  comp_z;
        logic                     point_done;
        logic                     batch_end_out;
    } out_item_t;

    function automatic logic signed [CORDIC_W-1:0] atan_turn(input logic [4:0] idx);
        logic signed [CORDIC_W-1:0] r;
        begin
            case (idx)
                5'd0:    r = CORDIC_W'(536870912);
                5'd1:    r = CORDIC_W'(316933406);
                5'd2:    r = CORDIC_W'(167458907);
                5'd3:    r = CORDIC_W'(85004756);
                5'd4:    r = CORDIC_W'(42667331);
                5'd5:    r = CORDIC_W'(21354465);
                5'd6:    r = CORDIC_W'(10679838);
                5'd7:    r = CORDIC_W'(5340245);
                5'd8:    r = CORDIC_W'(2670163);
                5'd9:    r = CORDIC_W'(1335087);
                5'd10:   r = CORDIC_W'(667544);
                5'd11:   r = CORDIC_W'(333772);
                5'd12:   r = CORDIC_W'(166886);
                5'd13:   r = CORDIC_W'(83443);
                5'd14:   r = CORDIC_W'(41722);
                5'd15:   r = CORDIC_W'(20861);
                5'd16:   r = CORDIC_W'(10430);
                5'd17:   r = CORDIC_W'(5215);
                5'd18:   r = CORDIC_W'(2608);
                5'd19:   r = CORDIC_W'(1304);
                5'd20:   r = CORDIC_W'(652);
                5'd21:   r = CORDIC_W'(326);
                5'd22:   r = CORDIC_W'(163);
                5'd23:   r = CORDIC_W'(81);
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/tse_cordic.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tse_cordic #(
    parameter int ANGLE_BITS = 16
) (
    input  wire logic                                 clk,
    input  wire logic [15:0]                          angle,
    input  wire logic [tse_pkg::CORDIC_STEPS-1:0]     load,
    output logic signed [tse_pkg::TRIG_W-1:0]         cos_val,
    output logic signed [tse_pkg::TRIG_W-1:0]         sin_val
);
    import tse_pkg::*;

    localparam logic [63:0] ANGLE_MASK = (64'd1 << ANGLE_BITS) - 64'd1;
    localparam int PH_SHIFT = 32 - ANGLE_BITS;

    logic [63:0] masked;
    logic [31:0] phase;

    logic signed [CORDIC_W-1:0] x_reg [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] y_reg [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] z_reg [CORDIC_STEPS];
    logic [1:0]                 q_reg [CORDIC_STEPS];

    assign masked = {48'd0, angle} & ANGLE_MASK;
    assign phase  = 32'(masked << PH_SHIFT);

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic signed [CORDIC_W-1:0] x_in;
        logic signed [CORDIC_W-1:0] y_in;
        logic signed [CORDIC_W-1:0] z_in;
        logic [1:0]                 q_in;
        logic signed [CORDIC_W-1:0] dx;
        logic signed [CORDIC_W-1:0] dy;
        if (i == 0) begin : g_first
            assign x_in = CORDIC_GAIN;
            assign y_in = '0;
            assign z_in = CORDIC_W'({1'b0, phase[29:0]});
            assign q_in = phase[31:30];
        end else begin : g_rest
            assign x_in = x_reg[i-1];
            assign y_in = y_reg[i-1];
            assign z_in = z_reg[i-1];
            assign q_in = q_reg[i-1];
        end
        assign dx = y_in >>> i;
        assign dy = x_in >>> i;
        always_ff @(posedge clk)
        begin
            if (load[i])
            begin
                q_reg[i] <= q_in;
                if (!z_in[CORDIC_W-1])
                begin
                    x_reg[i] <= x_in - dx;
                    y_reg[i] <= y_in + dy;
                    z_reg[i] <= z_in - atan_turn(5'(i));
                end
                else
                begin
                    x_reg[i] <= x_in + dx;
                    y_reg[i] <= y_in - dy;
                    z_reg[i] <= z_in + atan_turn(5'(i));
                end
            end
        end
    end

    always_comb
    begin
        case (q_reg[CORDIC_STEPS-1])
            2'd0:
            begin
                cos_val = TRIG_W'(x_reg[CORDIC_STEPS-1]);
                sin_val = TRIG_W'(y_reg[CORDIC_STEPS-1]);
            end
            2'd1:
            begin
                cos_val = TRIG_W'(-y_reg[CORDIC_STEPS-1]);
                sin_val = TRIG_W'(x_reg[CORDIC_STEPS-1]);
            end
            2'd2:
            begin
                cos_val = TRIG_W'(-x_reg[CORDIC_STEPS-1]);
                sin_val = TRIG_W'(-y_reg[CORDIC_STEPS-1]);
            end
            default:
            begin
                cos_val = TRIG_W'(y_reg[CORDIC_STEPS-1]);
                sin_val = TRIG_W'(-x_reg[CORDIC_STEPS-1]);
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/tse_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tse_seq #(
    parameter int A_W           = 33,
    parameter int P_W           = 66,
    parameter int OUT_FRAC_BITS = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  op_valid,
    output logic                                       op_ready,
    input  wire logic signed [A_W-1:0]                 fac,
    input  wire logic signed [A_W-1:0]                 rcv,
    input  wire logic signed [A_W-1:0]                 rsv,
    input  wire logic signed [tse_pkg::TRIG_W-1:0]     cu,
    input  wire logic signed [tse_pkg::TRIG_W-1:0]     su,
    input  wire logic signed [tse_pkg::TRIG_W-1:0]     sv,
    input  wire logic signed [2*tse_pkg::TRIG_W-1:0]   ncu,
    input  wire logic signed [2*tse_pkg::TRIG_W-1:0]   nsu,
    input  wire logic                                  batch,
    input  wire logic                                  minor_zero,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output tse_pkg::out_item_t                         out_data
);
    import tse_pkg::*;

    localparam int S_MID = MID_FRAC + TRIG_FRAC - OUT_FRAC_BITS;
    localparam int S_T2  = 2 * TRIG_FRAC - OUT_FRAC_BITS;
    localparam int M_W   = A_W + TRIG_W;
    localparam logic signed [P_W:0] HALF_MID = (P_W+1)'(1) <<< (S_MID - 1);
    localparam logic signed [P_W:0] HALF_T2  = (P_W+1)'(1) <<< (S_T2 - 1);
    localparam logic signed [P_W:0] MAX_V    = (P_W+1)'(8388607);
    localparam logic signed [P_W:0] MIN_V    = -MAX_V - (P_W+1)'(1);
    localparam logic signed [A_W-1:0] UNIT_A = A_W'(1) <<< MID_FRAC;
    localparam logic signed [TRIG_W-1:0] UNIT_T = TRIG_W'(1) <<< TRIG_FRAC;
    localparam logic [2:0] LAST_KIND = 3'(KIND_DVV);

    logic                        h_valid_reg;
    logic [2:0]                  cnt_reg;
    logic signed [A_W-1:0]       fac_reg, rcv_reg, rsv_reg;
    logic signed [TRIG_W-1:0]    cu_reg, su_reg, sv_reg;
    logic signed [2*TRIG_W-1:0]  ncu_reg, nsu_reg;
    logic                        batch_reg, sg_pos_reg, sg_neg_reg, mz_reg;

    logic                        p_valid_reg;
    logic [2:0]                  p_kind_reg;
    logic signed [P_W-1:0]       p0_reg, p1_reg, p2_reg;
    logic                        p_t2_reg, p_last_reg, p_batch_reg;

    logic                        o_valid_reg;
    out_item_t                   o_data_reg;

    logic o_load, p_load, gen_fire;
    logic signed [A_W-1:0]    a0, a1, a2, sg_a, sg2_a;
    logic signed [TRIG_W-1:0] t0, t1, t2;
    logic                     use_pre;
    logic signed [M_W-1:0]    m0, m1, m2;
    logic signed [2*TRIG_W-1:0] n0, n1;
    logic sg2_pos, sg2_neg;

    function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [P_W-1:0] p,
                                                          input logic two_trig);
        logic signed [P_W:0] ext, r;
        begin
            ext = (P_W+1)'(p);
            if (two_trig)
                r = (ext + HALF_T2) >>> S_T2;
            else
                r = (ext + HALF_MID) >>> S_MID;
            if (r > MAX_V)
                r = MAX_V;
            if (r < MIN_V)
                r = MIN_V;
            return OUT_W'(r);
        end
    endfunction

    assign o_load   = !o_valid_reg || !out_stall;
    assign p_load   = !p_valid_reg || o_load;
    assign gen_fire = h_valid_reg && p_load;
    assign op_ready = !h_valid_reg || (gen_fire && cnt_reg == LAST_KIND);

    assign sg2_pos = sg_pos_reg && !mz_reg;
    assign sg2_neg = sg_neg_reg && !mz_reg;

    always_comb
    begin
        sg_a  = sg_pos_reg ? UNIT_A : (sg_neg_reg ? -UNIT_A : '0);
        sg2_a = sg2_pos ? UNIT_A : (sg2_neg ? -UNIT_A : '0);
        n0 = sg2_pos ? ncu_reg : (sg2_neg ? -ncu_reg : '0);
        n1 = sg2_pos ? nsu_reg : (sg2_neg ? -nsu_reg : '0);
        use_pre = 1'b0;
        a0 = '0; a1 = '0; a2 = '0;
        t0 = '0; t1 = '0; t2 = '0;
        case (vector_kind_t'(cnt_reg))
            KIND_POS:
            begin
                a0 = fac_reg; t0 = cu_reg;
                a1 = fac_reg; t1 = su_reg;
                a2 = rsv_reg; t2 = UNIT_T;
            end
            KIND_DU:
            begin
                a0 = -sg_a; t0 = su_reg;
                a1 = sg_a;  t1 = cu_reg;
            end
            KIND_DV:
            begin
                a0 = -rsv_reg; t0 = cu_reg;
                a1 = -rsv_reg; t1 = su_reg;
                a2 = rcv_reg;  t2 = UNIT_T;
            end
            KIND_NORMAL:
            begin
                use_pre = 1'b1;
                a2 = sg2_a; t2 = sv_reg;
            end
            KIND_DUU:
            begin
                a0 = -fac_reg; t0 = cu_reg;
                a1 = -fac_reg; t1 = su_reg;
            end
            KIND_DUV:
            begin
                a0 = rsv_reg;  t0 = su_reg;
                a1 = -rsv_reg; t1 = cu_reg;
            end
            KIND_DVV:
            begin
                a0 = -rcv_reg; t0 = cu_reg;
                a1 = -rcv_reg; t1 = su_reg;
                a2 = -rsv_reg; t2 = UNIT_T;
            end
            default:
            begin
                use_pre = 1'b0;
            end
        endcase
    end

    assign m0 = a0 * t0;
    assign m1 = a1 * t1;
    assign m2 = a2 * t2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (op_ready)
            begin
                h_valid_reg <= op_valid;
                cnt_reg     <= '0;
            end
            else if (gen_fire)
            begin
                cnt_reg <= cnt_reg + 3'd1;
            end
            if (p_load)
                p_valid_reg <= gen_fire;
            if (o_load)
                o_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_ready)
        begin
            fac_reg    <= fac;
            rcv_reg    <= rcv;
            rsv_reg    <= rsv;
            cu_reg     <= cu;
            su_reg     <= su;
            sv_reg     <= sv;
            ncu_reg    <= ncu;
            nsu_reg    <= nsu;
            batch_reg  <= batch;
            mz_reg     <= minor_zero;
            sg_pos_reg <= !fac[A_W-1] && (fac != '0);
            sg_neg_reg <= fac[A_W-1];
        end
        if (gen_fire)
        begin
            p_kind_reg  <= cnt_reg;
            p0_reg      <= use_pre ? P_W'(n0) : P_W'(m0);
            p1_reg      <= use_pre ? P_W'(n1) : P_W'(m1);
            p2_reg      <= P_W'(m2);
            p_t2_reg    <= use_pre;
            p_last_reg  <= (cnt_reg == LAST_KIND);
            p_batch_reg <= batch_reg && (cnt_reg == LAST_KIND);
        end
        if (o_load && p_valid_reg)
        begin
            o_data_reg.vector_kind   <= p_kind_reg;
            o_data_reg.comp_x        <= round_sat(p0_reg, p_t2_reg);
            o_data_reg.comp_y        <= round_sat(p1_reg, p_t2_reg);
            o_data_reg.comp_z        <= round_sat(p2_reg, 1'b0);
            o_data_reg.point_done    <= p_last_reg;
            o_data_reg.batch_end_out <= p_batch_reg;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_data  = o_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/torus_surface_evaluator_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Signals                              | Item
// input    | in_valid, in_stall, in_data          | one (u, v) point
// output   | out_valid, out_stall, out_data       | one 3-vector
// config   | psel, penable, pwrite, paddr, pwdata | radius registers
// Each point yields seven output items in order; the single output sequencer takes the next
// point only as it issues the last item of the current one, and an output stall holds it.
// A point crosses 24 CORDIC stages, two product stages and three sequencer stages.
// Reset clears all valid bits and loads both radii with their defaults.
// A stall holds every stage that cannot drain and loses nothing.

module torus_surface_evaluator_top #(
    parameter int ANGLE_BITS       = 16,
    parameter int RADIUS_FRAC_BITS = 12,
    parameter int OUT_FRAC_BITS    = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire tse_pkg::in_item_t   in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output tse_pkg::out_item_t       out_data,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    import tse_pkg::*;

    localparam int RW    = 16 + MID_FRAC - RADIUS_FRAC_BITS;
    localparam int A_W   = (RW + 3 > 28) ? RW + 3 : 28;
    localparam int P_W   = (A_W + TRIG_W > 66) ? A_W + TRIG_W : 66;
    localparam int NS    = CORDIC_STEPS + 2;
    localparam int PR_W  = RW + 1 + TRIG_W;
    localparam logic signed [PR_W-1:0] HALF_T = PR_W'(1) <<< (TRIG_FRAC - 1);

    logic [15:0] major_reg, minor_reg;
    logic [NS-1:0] v_reg;
    logic [NS-1:0] ld;
    logic [CORDIC_STEPS-1:0] b_reg;
    logic seq_ready;

    logic signed [TRIG_W-1:0] cu_c, su_c, cv_c, sv_c;
    logic signed [RW:0] big_r, small_r;

    logic signed [TRIG_W-1:0]   cu_reg, su_reg, sv_reg;
    logic signed [PR_W-1:0]     prc_reg, prs_reg;
    logic signed [2*TRIG_W-1:0] ncu_reg, nsu_reg;
    logic                       b1_reg;

    logic signed [A_W-1:0]      fac_reg, rcv_reg, rsv_reg;
    logic signed [TRIG_W-1:0]   cu2_reg, su2_reg, sv2_reg;
    logic signed [2*TRIG_W-1:0] ncu2_reg, nsu2_reg;
    logic                       b2_reg;
    logic signed [PR_W-1:0]     rcv_full, rsv_full;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MINOR) ? {16'd0, minor_reg} : {16'd0, major_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            major_reg <= MAJOR_RESET;
            minor_reg <= MINOR_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_MAJOR)
                major_reg <= pwdata[15:0];
            else
                minor_reg <= pwdata[15:0];
        end
    end

    always_comb
    begin
        ld[NS-1] = !v_reg[NS-1] || seq_ready;
        for (int i = NS - 2; i >= 0; i--)
            ld[i] = !v_reg[i] || ld[i+1];
    end

    assign in_stall = !ld[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (ld[0])
                v_reg[0] <= in_valid;
            for (int i = 1; i < NS; i++)
                if (ld[i])
                    v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
            b_reg[0] <= in_data.batch_end_in;
        for (int i = 1; i < CORDIC_STEPS; i++)
            if (ld[i])
                b_reg[i] <= b_reg[i-1];
    end

    tse_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_u (
        .clk     (clk),
        .angle   (in_data.u_angle),
        .load    (ld[CORDIC_STEPS-1:0]),
        .cos_val (cu_c),
        .sin_val (su_c)
    );

    tse_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_v (
        .clk     (clk),
        .angle   (in_data.v_angle),
        .load    (ld[CORDIC_STEPS-1:0]),
        .cos_val (cv_c),
        .sin_val (sv_c)
    );

    assign big_r   = $signed({1'b0, major_reg, (MID_FRAC - RADIUS_FRAC_BITS)'(0)});
    assign small_r = $signed({1'b0, minor_reg, (MID_FRAC - RADIUS_FRAC_BITS)'(0)});

    assign rcv_full = (prc_reg + HALF_T) >>> TRIG_FRAC;
    assign rsv_full = (prs_reg + HALF_T) >>> TRIG_FRAC;

    always_ff @(posedge clk)
    begin
        if (ld[CORDIC_STEPS])
        begin
            cu_reg  <= cu_c;
            su_reg  <= su_c;
            sv_reg  <= sv_c;
            prc_reg <= small_r * cv_c;
            prs_reg <= small_r * sv_c;
            ncu_reg <= cu_c * cv_c;
            nsu_reg <= su_c * cv_c;
            b1_reg  <= b_reg[CORDIC_STEPS-1];
        end
        if (ld[CORDIC_STEPS+1])
        begin
            rcv_reg  <= A_W'(rcv_full);
            rsv_reg  <= A_W'(rsv_full);
            fac_reg  <= A_W'(big_r) + A_W'(rcv_full);
            cu2_reg  <= cu_reg;
            su2_reg  <= su_reg;
            sv2_reg  <= sv_reg;
            ncu2_reg <= ncu_reg;
            nsu2_reg <= nsu_reg;
            b2_reg   <= b1_reg;
        end
    end

    tse_seq #(
        .A_W           (A_W),
        .P_W           (P_W),
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_valid   (v_reg[NS-1]),
        .op_ready   (seq_ready),
        .fac        (fac_reg),
        .rcv        (rcv_reg),
        .rsv        (rsv_reg),
        .cu         (cu2_reg),
        .su         (su2_reg),
        .sv         (sv2_reg),
        .ncu        (ncu2_reg),
        .nsu        (nsu2_reg),
        .batch      (b2_reg),
        .minor_zero (minor_reg == 16'd0),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.point_done == (out_data.vector_kind == 3'(KIND_DVV))))
        else $error("point_done not on the last vector");

    a_batch_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.batch_end_out) |-> out_data.point_done)
        else $error("batch end flag outside the last vector");

    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[0] |-> !in_stall)
        else $error("input stalled while first stage is empty");

    a_kind_next: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && out_data.vector_kind == 3'(KIND_POS)) |=>
        (!out_valid || out_data.vector_kind == 3'(KIND_DU)))
        else $error("vector order broken after position");

endmodule

`default_nettype wire
